// File: src/stack_alu_pop_add_div_mod_unit_defines.svh
// assertion macros used by the stack alu
`ifndef STACK_ALU_POP_ADD_DIV_MOD_UNIT_DEFINES_SVH
`define STACK_ALU_POP_ADD_DIV_MOD_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SAM_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define SAM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SAM_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define SAM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/sam_pkg.sv
package sam_pkg;

    localparam int DATA_W          = 32;
    localparam int KIND_W          = 3;
    localparam int STATUS_W        = 3;
    localparam int DEPTH_W         = 7;
    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [KIND_W-1:0] OP_PUSH = 3'd0;
    localparam logic [KIND_W-1:0] OP_POP  = 3'd1;
    localparam logic [KIND_W-1:0] OP_ADD  = 3'd2;
    localparam logic [KIND_W-1:0] OP_DIV  = 3'd3;
    localparam logic [KIND_W-1:0] OP_MOD  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quot;
        logic [DATA_W-1:0] rem;
    } t_div_rsp;

endpackage

// File: src/sam_div.sv
module sam_div
    import sam_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEP_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DATA_W-1:0] r_quot;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_dvs;

    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_diff;

    // one restoring step per cycle, msb first
    assign w_shift = {r_rem, r_quot[DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_quot <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                if (!w_diff[DATA_W]) begin
                    r_rem  <= w_diff[DATA_W-1:0];
                    r_quot <= {r_quot[DATA_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_shift[DATA_W-1:0];
                    r_quot <= {r_quot[DATA_W-2:0], 1'b0};
                end
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

// File: src/stack_alu_pop_add_div_mod_unit.sv
// stack machine alu: a bounded lifo of signed 32-bit words
// input beats: s_axis_tuser carries the operation (push, pop, add, divide,
// modulo), s_axis_tdata the word to push. every input beat gives exactly one
// output beat: m_axis_tuser the status, m_axis_tdata the new top word and
// the depth. binary operations combine second-from-top with top, replace
// the second entry and pop the top; on any error the stack is left as is.
// output beats are registered. push, pop down to empty, pop on empty,
// too-short checks and unused codes finish in the idle state; other pops,
// add and a zero divisor pass a read state (one registered read of the
// stack memory for the entry below the top); divide and modulo then wait
// on the shared restoring divider, one quotient bit per cycle.
// one item is in work at a time; s_axis_tready is low until it completes.
// a finished result sits in the output register until m_axis_tready takes
// it; the next input beat is taken in the same cycle the result leaves.
// reset empties the stack (depth zero) and drops any pending result; the
// stack memory itself is not cleared, entries above the depth are unused.
`include "stack_alu_pop_add_div_mod_unit_defines.svh"

module stack_alu_pop_add_div_mod_unit
    import sam_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [DATA_W-1:0]             s_axis_tdata,   // push_value
    input  logic [KIND_W-1:0]             s_axis_tuser,   // kind
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [DATA_W+DEPTH_W:0]       m_axis_tdata,   // top_word, depth, pad
    output logic [STATUS_W-1:0]           m_axis_tuser    // status
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV
    } t_state;

    t_state              r_state,  n_state;
    logic [KIND_W-1:0]   r_kind,   n_kind;
    logic [CW-1:0]       r_count,  n_count;
    logic [DATA_W-1:0]   r_top,    n_top;
    logic                r_m_valid, n_m_valid;
    logic [STATUS_W-1:0] r_o_status, n_o_status;
    logic [DATA_W-1:0]   r_o_top,  n_o_top;
    logic [DEPTH_W-1:0]  r_o_depth, n_o_depth;

    logic [DATA_W-1:0]   mem [STACK_DEPTH];
    logic [DATA_W-1:0]   r_rd_data;
    logic                w_we;
    logic [AW-1:0]       w_wa;
    logic [DATA_W-1:0]   w_wd;

    logic [CW-1:0]       w_cnt_m2;
    logic [AW-1:0]       w_rd_idx;
    logic                w_accept;
    logic                w_fin;
    logic [STATUS_W-1:0] w_status;
    logic [DATA_W-1:0]   w_res;
    logic [CW+DEPTH_W-1:0] w_depth_ext;

    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    assign w_cnt_m2 = r_count - CW'(2);
    assign w_rd_idx = w_cnt_m2[AW-1:0];

    assign s_axis_tready = (r_state == S_IDLE) && (!r_m_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // stack memory: one write port, one registered read of the entry below top
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_rd_data <= mem[w_rd_idx];
    end

    sam_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_count    = r_count;
        n_top      = r_top;
        n_m_valid  = r_m_valid;
        n_o_status = r_o_status;
        n_o_top    = r_o_top;
        n_o_depth  = r_o_depth;
        w_we       = 1'b0;
        w_wa       = w_rd_idx;
        w_wd       = '0;
        w_fin      = 1'b0;
        w_status   = ST_OK;
        w_res      = '0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_rd_data[DATA_W-1] ? (DATA_W'(0) - r_rd_data) : r_rd_data;
        w_div_req.divisor  = r_top[DATA_W-1] ? (DATA_W'(0) - r_top) : r_top;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_kind = s_axis_tuser;
                    case (s_axis_tuser)
                        OP_PUSH: begin
                            w_fin = 1'b1;
                            if (r_count == CW'(STACK_DEPTH)) begin
                                w_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_wa    = r_count[AW-1:0];
                                w_wd    = s_axis_tdata;
                                n_top   = s_axis_tdata;
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                w_fin    = 1'b1;
                                w_status = ST_EMPTY;
                            end else if (r_count == CW'(1)) begin
                                w_fin   = 1'b1;
                                n_count = '0;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        OP_ADD, OP_DIV, OP_MOD: begin
                            if (r_count < CW'(2)) begin
                                w_fin    = 1'b1;
                                w_status = ST_SHORT;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            w_fin = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                case (r_kind)
                    OP_POP: begin
                        w_fin   = 1'b1;
                        n_top   = r_rd_data;
                        n_count = r_count - CW'(1);
                    end
                    OP_ADD: begin
                        w_fin   = 1'b1;
                        w_res   = r_rd_data + r_top;
                        w_we    = 1'b1;
                        w_wd    = w_res;
                        n_top   = w_res;
                        n_count = r_count - CW'(1);
                    end
                    default: begin
                        if (r_top == '0) begin
                            w_fin    = 1'b1;
                            w_status = ST_DIVZERO;
                        end else begin
                            w_div_req.start = 1'b1;
                            n_state         = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    if (r_kind == OP_DIV) begin
                        w_res = (r_rd_data[DATA_W-1] ^ r_top[DATA_W-1])
                              ? (DATA_W'(0) - w_div_rsp.quot) : w_div_rsp.quot;
                    end else begin
                        w_res = r_rd_data[DATA_W-1]
                              ? (DATA_W'(0) - w_div_rsp.rem) : w_div_rsp.rem;
                    end
                    w_fin   = 1'b1;
                    w_we    = 1'b1;
                    w_wd    = w_res;
                    n_top   = w_res;
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        w_depth_ext = {{DEPTH_W{1'b0}}, n_count};
        if (w_fin) begin
            n_state    = S_IDLE;
            n_m_valid  = 1'b1;
            n_o_status = w_status;
            n_o_top    = (n_count == '0) ? '0 : n_top;
            n_o_depth  = w_depth_ext[DEPTH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
        r_kind     <= n_kind;
        r_top      <= n_top;
        r_o_status <= n_o_status;
        r_o_top    <= n_o_top;
        r_o_depth  <= n_o_depth;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {1'b0, r_o_depth, r_o_top};

    `SAM_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(STACK_DEPTH), "stack count beyond depth")
    `SAM_ASSERT_NEXT(a_count_held, i_clk, i_rst_n, (r_state == S_DIV) && !w_div_rsp.done, $stable(r_count), "stack count moved during divide")
    `SAM_ASSERT_IMPL(a_divzero_kind, i_clk, i_rst_n, r_m_valid && (r_o_status == ST_DIVZERO), (r_kind == OP_DIV) || (r_kind == OP_MOD), "divide by zero reported for other operation")
    `SAM_ASSERT_IMPL(a_div_done_state, i_clk, i_rst_n, w_div_rsp.done, r_state == S_DIV, "divider finished outside divide state")

endmodule
